/* hw/rtl/fbpa_pkg.sv */
// package for the block pool allocator: sizes, field widths, codes
package fbpa_pkg;

	localparam int BLOCK_COUNT = 256;
	localparam int PTR_W       = $clog2(BLOCK_COUNT);
	localparam int CNT_W       = $clog2(BLOCK_COUNT + 1);

	localparam int IDX_W    = 8;
	localparam int ADDR_W   = 48;
	localparam int SIZE_W   = 17;
	localparam int PROD_W   = IDX_W + SIZE_W;
	localparam int STAT_W   = 2;
	localparam int DATA_W   = 64;
	localparam int PADDR_W  = 5;
	localparam int OUT_W    = IDX_W + 2 * ADDR_W;

	localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST = SIZE_W'(256);

	typedef enum logic [1:0] {
		REG_DEVICE_BASE = 2'd0,
		REG_HOST_BASE   = 2'd1,
		REG_BLOCK_SIZE  = 2'd2
	} reg_idx_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

endpackage

/* hw/rtl/fifo_block_pool_allocator_core.sv */
// block pool allocator with a fifo free list held in a ring memory
//
//  channel   dir  transaction            payload
//  s_*       in   tvalid & tready        tuser: command, tdata: free_index
//  m_*       out  tvalid & tready        tuser: status, tdata: index, dev, host
//  apb       in   psel&penable&pwrite    regs at 0x00, 0x08, 0x10
//
// one command at a time: accept, ring read and multiply, address add,
// so an item runs these steps in turn and waits at the last one until the result register is free.
// the ring memory read is registered; the multiply gets its own stage.
// reset clears pointers and the per-entry valid bits and sets the count to full;
// an entry never written reads as its own slot number, so no clearing pass is needed.
// a stalled m side holds one result while the next item is accepted and computed.
module fifo_block_pool_allocator_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [fbpa_pkg::IDX_W-1:0]  s_tdata,  // free_index
	input  logic                        s_tuser,  // command
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [fbpa_pkg::OUT_W-1:0]  m_tdata,  // block_index, device_address, host_address
	output logic [fbpa_pkg::STAT_W-1:0] m_tuser,  // status
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fbpa_pkg::PADDR_W-1:0] paddr,
	input  logic [fbpa_pkg::DATA_W-1:0] pwdata,
	output logic [fbpa_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import fbpa_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_OUT
	} state_t;

	state_t state_q;

	logic [ADDR_W-1:0] device_base_q;
	logic [ADDR_W-1:0] host_base_q;
	logic [SIZE_W-1:0] block_size_q;

	logic [IDX_W-1:0]       ring_mem [BLOCK_COUNT];
	logic [BLOCK_COUNT-1:0] ring_vld_q;
	logic [PTR_W-1:0]       head_q;
	logic [PTR_W-1:0]       tail_q;
	logic [CNT_W-1:0]       count_q;

	logic [IDX_W-1:0]  rd_s1;
	logic              vld_s1;
	logic [PTR_W-1:0]  head_s1;
	logic [STAT_W-1:0] status_s1;
	logic              alloc_s1;

	logic [IDX_W-1:0]  blk_s2;
	logic [PROD_W-1:0] prod_s2;
	logic [STAT_W-1:0] status_s2;
	logic              alloc_s2;

	logic             accept;
	logic             cfg_wr;
	reg_idx_t         cfg_idx;
	logic             is_empty;
	logic             is_full;
	logic             do_pop;
	logic             do_push;
	logic             out_free;
	logic [IDX_W-1:0] blk_s1;
	logic [PTR_W-1:0] head_nxt;
	logic [PTR_W-1:0] tail_nxt;

	assign pready   = 1'b1;
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign cfg_wr   = psel & penable & pwrite & pready;
	assign cfg_idx  = reg_idx_t'(paddr[4:3]);

	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == CNT_W'(BLOCK_COUNT));
	assign do_pop   = accept & (s_tuser == CMD_ALLOC) & ~is_empty;
	assign do_push  = accept & (s_tuser == CMD_FREE) & ~is_full;
	assign out_free = ~m_tvalid | m_tready;

	assign head_nxt = (head_q == PTR_W'(BLOCK_COUNT - 1)) ? '0 : head_q + 1'b1;
	assign tail_nxt = (tail_q == PTR_W'(BLOCK_COUNT - 1)) ? '0 : tail_q + 1'b1;
	assign blk_s1   = vld_s1 ? rd_s1 : IDX_W'(head_s1);

	always_comb begin
		case (cfg_idx)
			REG_DEVICE_BASE: prdata = DATA_W'(device_base_q);
			REG_HOST_BASE:   prdata = DATA_W'(host_base_q);
			REG_BLOCK_SIZE:  prdata = DATA_W'(block_size_q);
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_base_q <= '0;
			host_base_q   <= '0;
			block_size_q  <= BLOCK_SIZE_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_DEVICE_BASE: device_base_q <= pwdata[ADDR_W-1:0];
				REG_HOST_BASE:   host_base_q   <= pwdata[ADDR_W-1:0];
				REG_BLOCK_SIZE:  block_size_q  <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ring_mem[tail_q] <= s_tdata;
		end
		if (accept) begin
			rd_s1 <= ring_mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_vld_q <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= CNT_W'(BLOCK_COUNT);
		end else begin
			if (do_push) begin
				ring_vld_q[tail_q] <= 1'b1;
				tail_q             <= tail_nxt;
				count_q            <= count_q + 1'b1;
			end
			if (do_pop) begin
				head_q  <= head_nxt;
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_tvalid  <= 1'b0;
			m_tuser   <= '0;
			m_tdata   <= '0;
			vld_s1    <= 1'b0;
			head_s1   <= '0;
			alloc_s1  <= 1'b0;
			status_s1 <= '0;
			blk_s2    <= '0;
			prod_s2   <= '0;
			status_s2 <= '0;
			alloc_s2  <= 1'b0;
		end else begin
			if (m_tvalid && m_tready && state_q != S_OUT) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						vld_s1   <= ring_vld_q[head_q];
						head_s1  <= head_q;
						alloc_s1 <= do_pop;
						if (s_tuser == CMD_ALLOC) begin
							status_s1 <= is_empty ? ST_EMPTY : ST_OK;
						end else begin
							status_s1 <= is_full ? ST_FULL : ST_OK;
						end
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					blk_s2    <= blk_s1;
					prod_s2   <= PROD_W'(blk_s1) * PROD_W'(block_size_q);
					status_s2 <= status_s1;
					alloc_s2  <= alloc_s1;
					state_q   <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tuser  <= status_s2;
						if (alloc_s2) begin
							m_tdata <= {host_base_q + ADDR_W'(prod_s2),
								device_base_q + ADDR_W'(prod_s2), blk_s2};
						end else begin
							m_tdata <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
